FILE: src/fcds_pkg.sv
// Shared types and constants for the flow cell derived scalar unit.
// Holds the payload structs, mode and register codes, and the divider interface.
// No dependencies.
package fcds_pkg;

  // Scalar selection codes.
  localparam logic [3:0] MODE_RHO      = 4'd0;
  localparam logic [3:0] MODE_RHO_U    = 4'd1;
  localparam logic [3:0] MODE_RHO_V    = 4'd2;
  localparam logic [3:0] MODE_ENERGY   = 4'd3;
  localparam logic [3:0] MODE_U        = 4'd4;
  localparam logic [3:0] MODE_V        = 4'd5;
  localparam logic [3:0] MODE_U_X      = 4'd6;
  localparam logic [3:0] MODE_U_Y      = 4'd7;
  localparam logic [3:0] MODE_V_X      = 4'd8;
  localparam logic [3:0] MODE_V_Y      = 4'd9;
  localparam logic [3:0] MODE_DIV      = 4'd10;
  localparam logic [3:0] MODE_PRESSURE = 4'd11;

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALAR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA       = 2'd1;

  localparam logic [17:0] GAMMA_RESET = 18'd91750;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Quotient widths of the divider: 32 bits for velocities and gradients,
  // 50 bits for the kinetic energy term.
  localparam int QUO_SHORT_W = 32;
  localparam int QUO_LONG_W  = 50;

  // Clamp for the integer part of the pressure difference, +/- 2^32.
  localparam logic signed [36:0] P_Q_HI = 37'sh01_0000_0000;
  localparam logic signed [36:0] P_Q_LO = 37'sh1F_0000_0000;

  // A divisor of 1.0 in Q16.16, used when density is zero.
  localparam logic [30:0] ONE_Q16 = 31'd65536;

  typedef struct packed {
    logic        [30:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] total_energy;
    logic signed [31:0] density_dx;
    logic signed [31:0] density_dy;
    logic signed [31:0] momx_dx;
    logic signed [31:0] momx_dy;
    logic signed [31:0] momy_dx;
    logic signed [31:0] momy_dy;
    logic               last_cell;
  } fcds_in_t;

  typedef struct packed {
    logic signed [31:0] scalar_value;
    logic signed [31:0] running_min;
    logic signed [31:0] running_max;
    logic               pass_done;
  } fcds_out_t;

  typedef struct packed {
    logic               start;
    logic        [63:0] num;
    logic        [30:0] den;
    logic               long_q;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [QUO_LONG_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: src/fcds_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned 64-bit dividend by a 31-bit divisor, 32- or 50-bit quotient with overflow flag.
// Depends on fcds_pkg.
module fcds_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fcds_pkg::div_req_t req_i,
  output fcds_pkg::div_rsp_t rsp_o
);
  import fcds_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

  dstate_t               state_r;
  logic [63:0]           num_r;
  logic [30:0]           den_r;
  logic                  long_r;
  logic [30:0]           rem_r;
  logic [QUO_LONG_W-1:0] shift_r;
  logic [QUO_LONG_W-1:0] quo_r;
  logic [5:0]            cnt_r;
  logic                  ovf_r;
  logic                  done_r;

  logic [31:0] hi;
  logic        ovf_chk;
  logic [31:0] trial;
  logic        fits;
  logic [31:0] trial_sub;

  // The quotient fits only if the bits above it are below the divisor.
  assign hi        = long_r ? {18'd0, num_r[63:50]} : num_r[63:32];
  assign ovf_chk   = hi >= {1'b0, den_r};
  assign trial     = {rem_r, shift_r[QUO_LONG_W-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (req_i.start) begin
            num_r   <= req_i.num;
            den_r   <= req_i.den;
            long_r  <= req_i.long_q;
            state_r <= D_CHECK;
          end
        end
        D_CHECK: begin
          rem_r   <= hi[30:0];
          shift_r <= long_r ? num_r[QUO_LONG_W-1:0] : {num_r[31:0], 18'd0};
          quo_r   <= '0;
          ovf_r   <= ovf_chk;
          cnt_r   <= long_r ? 6'(QUO_LONG_W) : 6'(QUO_SHORT_W);
          if (ovf_chk) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r   <= fits ? trial_sub[30:0] : trial[30:0];
          shift_r <= {shift_r[QUO_LONG_W-2:0], 1'b0};
          quo_r   <= {quo_r[QUO_LONG_W-2:0], fits};
          cnt_r   <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.ovf  = ovf_r;
  assign rsp_o.quo  = quo_r;

endmodule

FILE: src/fcds_seq.sv
// Sequencer and datapath for one cell: velocities, gradients, divergence, pressure.
// Drives one shared divider and one shared registered 33x33 multiplier.
// Depends on fcds_pkg and fcds_div.
module fcds_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  fcds_pkg::fcds_in_t  item_i,
  input  logic [3:0]          mode_i,
  input  logic [17:0]         gamma_i,
  input  logic                ack_i,
  output logic                idle_o,
  output logic                res_valid_o,
  output logic signed [31:0]  res_o
);
  import fcds_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_VEL_START, S_VEL_WAIT, S_VEL_END,
    S_GR_MUL, S_GR_SUB, S_GR_DIV, S_GR_WAIT, S_GR_END,
    S_P_SQX, S_P_SQY, S_P_SUM, S_P_KDIV, S_P_KWAIT, S_P_DIFF, S_P_CLAMP,
    S_P_MLO, S_P_MHI, S_P_ADD, S_P_SAT, S_DONE
  } state_t;

  state_t              state_r;
  fcds_in_t            item_r;
  logic signed [31:0]  vel_r;
  logic signed [31:0]  g_r;
  logic signed [31:0]  g1_r;
  logic                second_r;
  logic                neg_r;
  logic signed [63:0]  num_r;
  logic        [63:0]  acc_r;
  logic        [50:0]  kin_r;
  logic signed [52:0]  diff_r;
  logic signed [49:0]  dcl_r;
  logic signed [65:0]  part_r;
  logic signed [68:0]  tot_r;
  logic signed [31:0]  res_r;
  logic signed [65:0]  prod_r;

  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                rho_zero;
  logic                use_v;
  logic signed [31:0]  m_sel;
  logic        [31:0]  m_abs;
  logic signed [31:0]  dm_sel;
  logic signed [31:0]  drho_sel;
  logic        [63:0]  num_abs;
  logic signed [18:0]  gm1;
  logic signed [36:0]  q_hi;
  logic signed [33:0]  q_cl;
  logic signed [68:0]  sat_sh;
  logic signed [31:0]  p_sat;
  logic        [32:0]  sum33;
  logic signed [31:0]  div_sum;

  // Signed saturation of a quotient given as magnitude, overflow flag and sign.
  function automatic logic signed [31:0] sat_sm(input logic [31:0] mag, input logic ovf,
                                                input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (ovf || mag > 32'h8000_0000) r = S32_MIN;
      else r = -$signed(mag);
    end else begin
      if (ovf || mag[31]) r = S32_MAX;
      else r = $signed(mag);
    end
    return r;
  endfunction

  fcds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign rho_zero = (item_r.density == 31'd0);
  assign gm1      = $signed({1'b0, gamma_i}) - 19'sd65536;

  // The second half of the divergence works on v and its y gradient.
  always_comb begin
    use_v    = (mode_i == MODE_V) || (mode_i == MODE_V_X) || (mode_i == MODE_V_Y) ||
               ((mode_i == MODE_DIV) && second_r);
    dm_sel   = item_r.momx_dx;
    drho_sel = item_r.density_dx;
    case (mode_i)
      MODE_U_X: begin
        dm_sel   = item_r.momx_dx;
        drho_sel = item_r.density_dx;
      end
      MODE_U_Y: begin
        dm_sel   = item_r.momx_dy;
        drho_sel = item_r.density_dy;
      end
      MODE_V_X: begin
        dm_sel   = item_r.momy_dx;
        drho_sel = item_r.density_dx;
      end
      MODE_V_Y: begin
        dm_sel   = item_r.momy_dy;
        drho_sel = item_r.density_dy;
      end
      MODE_DIV: begin
        dm_sel   = second_r ? item_r.momy_dy : item_r.momx_dx;
        drho_sel = second_r ? item_r.density_dy : item_r.density_dx;
      end
      default: begin
        dm_sel   = item_r.momx_dx;
        drho_sel = item_r.density_dx;
      end
    endcase
  end

  assign m_sel   = use_v ? item_r.momentum_y : item_r.momentum_x;
  assign m_abs   = m_sel[31] ? (~m_sel + 32'd1) : m_sel;
  assign num_abs = num_r[63] ? (~num_r + 64'd1) : num_r;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_GR_MUL: begin
        mul_a = {vel_r[31], vel_r};
        mul_b = {drho_sel[31], drho_sel};
      end
      S_P_SQX: begin
        mul_a = {item_r.momentum_x[31], item_r.momentum_x};
        mul_b = {item_r.momentum_x[31], item_r.momentum_x};
      end
      S_P_SQY: begin
        mul_a = {item_r.momentum_y[31], item_r.momentum_y};
        mul_b = {item_r.momentum_y[31], item_r.momentum_y};
      end
      S_P_MLO: begin
        mul_a = {8'd0, dcl_r[24:0]};
        mul_b = {{14{gm1[18]}}, gm1};
      end
      S_P_MHI: begin
        mul_a = {{8{dcl_r[49]}}, dcl_r[49:25]};
        mul_b = {{14{gm1[18]}}, gm1};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Divider requests.
  always_comb begin
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = item_r.density;
    div_req.long_q = 1'b0;
    case (state_r)
      S_VEL_START: begin
        div_req.start = !rho_zero;
        div_req.num   = {16'd0, m_abs, 16'd0};
      end
      S_GR_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = num_abs;
        div_req.den   = rho_zero ? ONE_Q16 : item_r.density;
      end
      S_P_KDIV: begin
        div_req.start  = !rho_zero;
        div_req.num    = {1'b0, acc_r[63:1]};
        div_req.long_q = 1'b1;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // Pressure clamp and final saturation.
  assign q_hi = diff_r[52:16];
  always_comb begin
    if (q_hi > P_Q_HI) q_cl = P_Q_HI[33:0];
    else if (q_hi < P_Q_LO) q_cl = P_Q_LO[33:0];
    else q_cl = q_hi[33:0];
  end

  assign sat_sh = tot_r >>> 16;
  always_comb begin
    if (!sat_sh[68] && (|sat_sh[67:31])) p_sat = S32_MAX;
    else if (sat_sh[68] && !(&sat_sh[67:31])) p_sat = S32_MIN;
    else p_sat = sat_sh[31:0];
  end

  assign sum33 = {g1_r[31], g1_r} + {g_r[31], g_r};
  assign div_sum = (sum33[32] != sum33[31]) ? (sum33[32] ? S32_MIN : S32_MAX)
                                            : sum33[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start_i) begin
            item_r   <= item_i;
            second_r <= 1'b0;
            state_r  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (mode_i)
            MODE_RHO: begin
              res_r   <= {1'b0, item_r.density};
              state_r <= S_DONE;
            end
            MODE_RHO_U: begin
              res_r   <= item_r.momentum_x;
              state_r <= S_DONE;
            end
            MODE_RHO_V: begin
              res_r   <= item_r.momentum_y;
              state_r <= S_DONE;
            end
            MODE_ENERGY: begin
              res_r   <= item_r.total_energy;
              state_r <= S_DONE;
            end
            MODE_U, MODE_V, MODE_U_X, MODE_U_Y, MODE_V_X, MODE_V_Y, MODE_DIV: begin
              state_r <= S_VEL_START;
            end
            MODE_PRESSURE: begin
              state_r <= S_P_SQX;
            end
            default: begin
              res_r   <= '0;
              state_r <= S_DONE;
            end
          endcase
        end
        S_VEL_START: begin
          if (rho_zero) begin
            vel_r   <= '0;
            state_r <= S_VEL_END;
          end else begin
            state_r <= S_VEL_WAIT;
          end
        end
        S_VEL_WAIT: begin
          if (div_rsp.done) begin
            vel_r   <= sat_sm(div_rsp.quo[31:0], div_rsp.ovf, m_sel[31]);
            state_r <= S_VEL_END;
          end
        end
        S_VEL_END: begin
          if ((mode_i == MODE_U) || (mode_i == MODE_V)) begin
            res_r   <= vel_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_GR_MUL;
          end
        end
        S_GR_MUL: state_r <= S_GR_SUB;
        S_GR_SUB: begin
          num_r   <= {{16{dm_sel[31]}}, dm_sel, 16'd0} - prod_r[63:0];
          state_r <= S_GR_DIV;
        end
        S_GR_DIV: begin
          neg_r   <= num_r[63];
          state_r <= S_GR_WAIT;
        end
        S_GR_WAIT: begin
          if (div_rsp.done) begin
            g_r     <= sat_sm(div_rsp.quo[31:0], div_rsp.ovf, neg_r);
            state_r <= S_GR_END;
          end
        end
        S_GR_END: begin
          if ((mode_i == MODE_DIV) && !second_r) begin
            g1_r     <= g_r;
            second_r <= 1'b1;
            state_r  <= S_VEL_START;
          end else if (mode_i == MODE_DIV) begin
            res_r   <= div_sum;
            state_r <= S_DONE;
          end else begin
            res_r   <= g_r;
            state_r <= S_DONE;
          end
        end
        S_P_SQX: state_r <= S_P_SQY;
        S_P_SQY: begin
          acc_r   <= prod_r[63:0];
          state_r <= S_P_SUM;
        end
        S_P_SUM: begin
          acc_r   <= acc_r + prod_r[63:0];
          state_r <= S_P_KDIV;
        end
        S_P_KDIV: begin
          if (rho_zero) begin
            kin_r   <= '0;
            state_r <= S_P_DIFF;
          end else begin
            state_r <= S_P_KWAIT;
          end
        end
        S_P_KWAIT: begin
          if (div_rsp.done) begin
            // An overflowing kinetic term drives the pressure difference to its clamp anyway.
            kin_r   <= div_rsp.ovf ? {1'b1, 50'd0} : {1'b0, div_rsp.quo};
            state_r <= S_P_DIFF;
          end
        end
        S_P_DIFF: begin
          diff_r  <= {{21{item_r.total_energy[31]}}, item_r.total_energy} - {2'b00, kin_r};
          state_r <= S_P_CLAMP;
        end
        S_P_CLAMP: begin
          dcl_r   <= {q_cl, diff_r[15:0]};
          state_r <= S_P_MLO;
        end
        S_P_MLO: state_r <= S_P_MHI;
        S_P_MHI: begin
          part_r  <= prod_r;
          state_r <= S_P_ADD;
        end
        S_P_ADD: begin
          tot_r   <= ({{3{prod_r[65]}}, prod_r} <<< 25) + {{3{part_r[65]}}, part_r};
          state_r <= S_P_SAT;
        end
        S_P_SAT: begin
          res_r   <= p_sat;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (ack_i) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle_o      = (state_r == S_IDLE);
  assign res_valid_o = (state_r == S_DONE);
  assign res_o       = res_r;

endmodule

FILE: src/flow_cell_derived_scalar_unit.sv
// Flow cell derived scalar unit: one cell in, one selected Q16.16 scalar out.
// Raw fields pass straight through; u or v takes one division, a velocity gradient two,
// divergence four, pressure one long one; the divider yields one quotient bit per cycle.
// A new cell is accepted only once the previous result has left for the output register.
// A finished result waits in the output register while the next cell is accepted.
// Synchronous active-low reset restores mode, gamma and the pass extremes.
module flow_cell_derived_scalar_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fcds_pkg::fcds_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fcds_pkg::fcds_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcds_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fcds_pkg::*;

  logic [3:0]         mode_r;
  logic [17:0]        gamma_r;
  logic signed [31:0] min_r;
  logic signed [31:0] max_r;
  logic               last_r;
  logic               out_valid_r;
  fcds_out_t          out_r;

  logic               seq_idle;
  logic               res_valid;
  logic signed [31:0] res;
  logic               accept;
  logic               ack;
  logic signed [31:0] min_nxt;
  logic signed [31:0] max_nxt;

  fcds_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (accept),
    .item_i      (in_data),
    .mode_i      (mode_r),
    .gamma_i     (gamma_r),
    .ack_i       (ack),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_stall  = !seq_idle;
  assign accept    = in_valid && seq_idle;
  assign cfg_ready = 1'b1;

  // A result moves out once the output register is empty or draining.
  assign ack     = res_valid && (!out_valid_r || !out_stall);
  assign min_nxt = (res < min_r) ? res : min_r;
  assign max_nxt = (res > max_r) ? res : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RHO;
      gamma_r     <= GAMMA_RESET;
      min_r       <= S32_MAX;
      max_r       <= S32_MIN;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SCALAR_MODE: mode_r  <= cfg_data[3:0];
          CFG_GAMMA:       gamma_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) last_r <= in_data.last_cell;
      if (ack) begin
        out_r.scalar_value <= res;
        out_r.running_min  <= min_nxt;
        out_r.running_max  <= max_nxt;
        out_r.pass_done    <= last_r;
        out_valid_r        <= 1'b1;
        min_r              <= last_r ? S32_MAX : min_nxt;
        max_r              <= last_r ? S32_MIN : max_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.running_min <= out_r.running_max)
    else $error("running minimum above running maximum");

  a_scalar_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.running_min <= out_r.scalar_value) &&
                    (out_r.scalar_value <= out_r.running_max))
    else $error("scalar outside the pass extremes");

  a_pass_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ack && last_r |=> (min_r == S32_MAX) && (max_r == S32_MIN))
    else $error("extremes not cleared after the last cell");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a cell is in progress");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for flow_cell_derived_scalar_unit: random and directed cells,
// a local predictor of the selected scalar and its pass extremes, and register writes.
// Depends on fcds_pkg and the unit itself.
`timescale 1ns / 100ps

module tb;
  import fcds_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;
  localparam int RANDOM_CELLS = 800;
  localparam int TAIL_CYCLES = 200;
  localparam longint Q_ONE = 64'sd65536;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam longint Q_CLAMP = 64'sd1 <<< 40;
  // Indexes past the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [CFG_DATA_W-1:0] GAMMA_TOP = 18'h3FFFF;
  localparam logic [3:0] MODE_UNUSED_LO = 4'd12;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  typedef enum logic [1:0] {OP_CELL, OP_REG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t               kind;
    fcds_in_t               payload;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } stim_op_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  fcds_in_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  fcds_out_t               out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  stim_op_t  stim_q[$];
  fcds_out_t expected_results[$];

  logic [3:0]            shadow_mode;
  logic [CFG_DATA_W-1:0] shadow_gamma;
  longint                pass_low;
  longint                pass_high;

  int mismatch_count;
  int cycle_count;
  int in_flight;
  int gap_left;
  int stall_left;
  int send_calm;
  int recv_calm;

  flow_cell_derived_scalar_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint cell_velocity(longint mom, longint rho);
    if (rho == 0) return 0;
    return sat_word((mom * Q_ONE) / rho);
  endfunction

  // Zero density divides the gradient numerator by 1.0 instead.
  function automatic longint cell_gradient(longint dm, longint vel, longint drho, longint rho);
    longint num;
    longint d;
    num = dm * Q_ONE - vel * drho;
    d = (rho != 0) ? rho : Q_ONE;
    return sat_word(num / d);
  endfunction

  function automatic longint cell_pressure(longint mx, longint my, longint e, longint rho,
                                           logic [CFG_DATA_W-1:0] gam);
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned sq;
    longint kin;
    longint diff;
    longint q;
    longint r;
    longint gm1;
    longint res;
    longint t;
    longint tq;
    kin = 0;
    if (rho != 0) begin
      ax = (mx < 0) ? -mx : mx;
      ay = (my < 0) ? -my : my;
      sq = (ax * ax + ay * ay) >> 1;
      kin = sq / longint'(rho);
    end
    diff = e - kin;
    // Floor split of the difference into integer and fraction parts.
    q = diff / Q_ONE;
    r = diff % Q_ONE;
    if (r < 0) begin
      q = q - 1;
      r = r + Q_ONE;
    end
    if (q > Q_CLAMP) q = Q_CLAMP;
    if (q < -Q_CLAMP) q = -Q_CLAMP;
    gm1 = longint'(gam) - Q_ONE;
    res = q * gm1;
    t = r * gm1;
    tq = t / Q_ONE;
    if (t % Q_ONE < 0) tq = tq - 1;
    return sat_word(res + tq);
  endfunction

  function automatic fcds_out_t predict_scalar(fcds_in_t c);
    longint rho;
    longint mx;
    longint my;
    longint u;
    longint v;
    longint s;
    fcds_out_t o;
    rho = longint'(c.density);
    mx = longint'($signed(c.momentum_x));
    my = longint'($signed(c.momentum_y));
    u = cell_velocity(mx, rho);
    v = cell_velocity(my, rho);
    case (shadow_mode)
      MODE_RHO:      s = rho;
      MODE_RHO_U:    s = mx;
      MODE_RHO_V:    s = my;
      MODE_ENERGY:   s = longint'($signed(c.total_energy));
      MODE_U:        s = u;
      MODE_V:        s = v;
      MODE_U_X:      s = cell_gradient(longint'($signed(c.momx_dx)), u,
                                       longint'($signed(c.density_dx)), rho);
      MODE_U_Y:      s = cell_gradient(longint'($signed(c.momx_dy)), u,
                                       longint'($signed(c.density_dy)), rho);
      MODE_V_X:      s = cell_gradient(longint'($signed(c.momy_dx)), v,
                                       longint'($signed(c.density_dx)), rho);
      MODE_V_Y:      s = cell_gradient(longint'($signed(c.momy_dy)), v,
                                       longint'($signed(c.density_dy)), rho);
      MODE_DIV:      s = sat_word(cell_gradient(longint'($signed(c.momx_dx)), u,
                                                longint'($signed(c.density_dx)), rho) +
                                  cell_gradient(longint'($signed(c.momy_dy)), v,
                                                longint'($signed(c.density_dy)), rho));
      MODE_PRESSURE: s = cell_pressure(mx, my, longint'($signed(c.total_energy)), rho,
                                       shadow_gamma);
      default:       s = 0;
    endcase
    if (s < pass_low) pass_low = s;
    if (s > pass_high) pass_high = s;
    o.scalar_value = s[31:0];
    o.running_min = pass_low[31:0];
    o.running_max = pass_high[31:0];
    o.pass_done = c.last_cell;
    if (c.last_cell) begin
      pass_low = WORD_MAX;
      pass_high = WORD_MIN;
    end
    return o;
  endfunction

  function automatic void write_shadow(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_SCALAR_MODE) shadow_mode = data[3:0];
    else if (idx == CFG_GAMMA) shadow_gamma = data;
  endfunction

  // Mostly no idle, some short gaps, a few long ones, and now and then a calm stretch.
  function automatic int idle_length(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 90);
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = '0;
      3, 4: w = $urandom;
      default: begin
        w = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) w = -w;
      end
    endcase
    return w;
  endfunction

  function automatic logic [30:0] rand_density();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = 32'h7FFF_FFFF;
      2: w = 32'(ONE_Q16);
      3: w = $urandom_range(1, 3);
      4: w = $urandom_range(32768, 262144);
      default: w = $urandom >> $urandom_range(1, 31);
    endcase
    return w[30:0];
  endfunction

  function automatic fcds_in_t rand_cell(logic last);
    fcds_in_t c;
    c.density = rand_density();
    c.momentum_x = rand_word();
    c.momentum_y = rand_word();
    c.total_energy = rand_word();
    c.density_dx = rand_word();
    c.density_dy = rand_word();
    c.momx_dx = rand_word();
    c.momx_dy = rand_word();
    c.momy_dx = rand_word();
    c.momy_dy = rand_word();
    c.last_cell = last;
    return c;
  endfunction

  // Corner cells: all fields at the top, all at the bottom, the smallest nonzero density against
  // mixed extremes, zero density, and density near 1.0.
  function automatic fcds_in_t edge_cell(int kind, logic last);
    fcds_in_t c;
    case (kind)
      0: c = {31'h7FFF_FFFF, {9{32'h7FFF_FFFF}}, last};
      1: c = {31'd0, {9{32'h8000_0000}}, last};
      2: begin
        c = {31'd1, {9{32'h8000_0000}}, last};
        c.momentum_y = 32'h7FFF_FFFF;
        c.total_energy = 32'h7FFF_FFFF;
        c.density_dx = 32'h7FFF_FFFF;
        c.momy_dy = 32'h7FFF_FFFF;
      end
      3: begin
        c = rand_cell(last);
        c.density = '0;
      end
      default: begin
        c = rand_cell(last);
        c.density = 31'($urandom_range(49152, 98304));
      end
    endcase
    return c;
  endfunction

  function automatic void add_cell(fcds_in_t c);
    stim_op_t op;
    op.kind = OP_CELL;
    op.payload = c;
    op.idx = '0;
    op.data = '0;
    stim_q.push_back(op);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_op_t op;
    op.kind = OP_REG;
    op.payload = '0;
    op.idx = idx;
    op.data = data;
    stim_q.push_back(op);
  endfunction

  function automatic void add_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.payload = '0;
    op.idx = '0;
    op.data = '0;
    stim_q.push_back(op);
  endfunction

  // Register writes and pauses wait until every issued cell has produced its result.
  always @(posedge clk) begin : cell_driver
    stim_op_t op;
    logic in_fire;
    logic reg_fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      in_flight = 0;
      gap_left = 0;
    end else begin
      in_fire = in_valid && !in_stall;
      reg_fire = cfg_valid && cfg_ready;
      if (in_fire) begin
        expected_results.push_back(predict_scalar(in_data));
        in_flight++;
        gap_left = idle_length(send_calm);
      end
      if (out_valid && !out_stall) in_flight--;
      if (reg_fire) write_shadow(cfg_index, cfg_data);
      if ((in_valid && !in_fire) || (cfg_valid && !reg_fire)) begin
        // Hold the stalled transaction as it is.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        gap_left--;
      end else if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (stim_q[0].kind == OP_CELL) begin
        op = stim_q.pop_front();
        in_valid <= 1'b1;
        in_data <= op.payload;
        cfg_valid <= 1'b0;
      end else if (in_flight != 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        op = stim_q.pop_front();
        in_valid <= 1'b0;
        cfg_valid <= (op.kind == OP_REG);
        cfg_index <= op.idx;
        cfg_data <= op.data;
      end
    end
  end

  always @(posedge clk) begin : result_check
    fcds_out_t want;
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: scalar_value %0d", out_data.scalar_value);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.scalar_value !== want.scalar_value) begin
            $error("scalar_value: expected %0d, got %0d", want.scalar_value,
                   out_data.scalar_value);
            mismatch_count++;
          end
          if (out_data.running_min !== want.running_min) begin
            $error("running_min: expected %0d, got %0d", want.running_min,
                   out_data.running_min);
            mismatch_count++;
          end
          if (out_data.running_max !== want.running_max) begin
            $error("running_max: expected %0d, got %0d", want.running_max,
                   out_data.running_max);
            mismatch_count++;
          end
          if (out_data.pass_done !== want.pass_done) begin
            $error("pass_done: expected %0b, got %0b", want.pass_done, out_data.pass_done);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        n = idle_length(recv_calm);
        out_stall <= (n > 0);
        stall_left <= (n > 0) ? n - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[flow_cell_derived_scalar_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] gamma_list[5];
    logic [3:0] mode;
    logic [CFG_DATA_W-1:0] gam;
    logic last;
    int planned;
    int phase_len;
    int pass_left;
    int k;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_calm = 0;
    recv_calm = 0;
    shadow_mode = MODE_RHO;
    shadow_gamma = GAMMA_RESET;
    pass_low = WORD_MAX;
    pass_high = WORD_MIN;

    // Directed part: every mode, unused ones included, on corner cells, in reset state first.
    add_cell(edge_cell(0, 1'b0));
    for (k = 0; k <= int'(MODE_UNUSED_HI); k++) begin
      add_drain();
      add_reg(CFG_SCALAR_MODE, CFG_DATA_W'(k));
      add_cell(edge_cell(k % 4, (k % 3) == 2));
    end
    // Spare indexes must leave mode and gamma alone.
    add_reg(CFG_SPARE_A, GAMMA_TOP);
    add_reg(CFG_SPARE_B, '0);
    add_reg(CFG_SCALAR_MODE, {14'h3FFF, MODE_PRESSURE});
    gamma_list = '{18'd0, 18'd32768, 18'd65536, 18'd196608, GAMMA_TOP};
    for (k = 0; k < 5; k++) begin
      add_drain();
      add_reg(CFG_GAMMA, gamma_list[k]);
      add_cell(edge_cell((k % 2 == 0) ? 4 : 2, k == 4));
    end

    // Random part: configuration phases, each carrying several passes of cells.
    planned = 0;
    pass_left = 0;
    while (planned < RANDOM_CELLS) begin
      add_drain();
      if ($urandom_range(0, 3) == 0)
        add_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                CFG_DATA_W'($urandom));
      if ($urandom_range(0, 7) == 0)
        mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else mode = 4'($urandom_range(MODE_RHO, MODE_PRESSURE));
      add_reg(CFG_SCALAR_MODE, {14'($urandom), mode});
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0: gam = CFG_DATA_W'($urandom_range(0, 65535));
          1: gam = GAMMA_TOP;
          2: gam = 18'd65536;
          3: gam = 18'd196608;
          default: gam = CFG_DATA_W'($urandom_range(65536, 196608));
        endcase
        add_reg(CFG_GAMMA, gam);
      end
      phase_len = $urandom_range(25, 60);
      for (k = 0; k < phase_len; k++) begin
        if (pass_left == 0) pass_left = $urandom_range(1, 16);
        pass_left--;
        last = (pass_left == 0);
        // A few passes are cut short or run past their marker.
        if ($urandom_range(0, 19) == 0) last = 1'($urandom_range(0, 1));
        add_cell(rand_cell(last));
        if (k == phase_len / 2 && $urandom_range(0, 3) == 0) add_drain();
      end
      planned += phase_len;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (stim_q.size() != 0 || in_valid || cfg_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[flow_cell_derived_scalar_unit] OK");
    end else begin
      $display("[flow_cell_derived_scalar_unit] ERROR");
    end
    $finish;
  end

endmodule
